/* design/l2c_pkg.sv */
`default_nettype none

package l2c_pkg;

   // Latin codes that the matcher looks at directly.
   localparam logic [6:0] CH_UC_A = 7'h41;
   localparam logic [6:0] CH_UC_Z = 7'h5A;
   localparam logic [6:0] CH_LC_A = 7'h61;
   localparam logic [6:0] CH_LC_Z = 7'h7A;
   localparam logic [6:0] CH_LC_C = 7'h63;
   localparam logic [6:0] CH_LC_H = 7'h68;
   localparam logic [6:0] CH_LC_S = 7'h73;
   localparam logic [6:0] CH_UC_S = 7'h53;
   localparam logic [6:0] CH_UC_X = 7'h58;
   localparam logic [6:0] CH_LC_X = 7'h78;

   // Cyrillic codes that are emitted outside the letter table.
   localparam logic [15:0] CYR_LC_ES    = 16'h0441;
   localparam logic [15:0] CYR_LC_KA    = 16'h043A;
   localparam logic [15:0] CYR_LC_SHCHA = 16'h0449;
   localparam logic [15:0] CYR_UC_SHCHA = 16'h0429;

   // Single-letter mapping for capitals A to Z and for small a to z.
   localparam logic [15:0] UPPER_MAP [26] = '{
      16'h0410, 16'h0411, 16'h041A, 16'h0414, 16'h0415, 16'h0424, 16'h0490,
      16'h0413, 16'h0406, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D,
      16'h041E, 16'h041F, 16'h041A, 16'h0420, 16'h0421, 16'h0422, 16'h0423,
      16'h0412, 16'h0412, 16'h041A, 16'h0418, 16'h0417
   };
   localparam logic [15:0] LOWER_MAP [26] = '{
      16'h0430, 16'h0431, 16'h043A, 16'h0434, 16'h0435, 16'h0444, 16'h0491,
      16'h0433, 16'h0456, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D,
      16'h043E, 16'h043F, 16'h043A, 16'h0440, 16'h0441, 16'h0442, 16'h0443,
      16'h0432, 16'h0432, 16'h043A, 16'h0438, 16'h0437
   };

   // True for a Latin letter in either case.
   function automatic logic is_letter(input logic [6:0] c);
      return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
   endfunction

   // Table code of a Latin letter; the caller has checked that it is one.
   function automatic logic [15:0] letter_code(input logic [6:0] c);
      logic [6:0] off;
      if (c <= CH_UC_Z) begin
         off = c - CH_UC_A;
         return UPPER_MAP[off[4:0]];
      end
      off = c - CH_LC_A;
      return LOWER_MAP[off[4:0]];
   endfunction

   // True for a letter that may open a digraph, and so has to be held back.
   function automatic logic is_lead(input logic [6:0] c);
      case (c)
         7'h7A, 7'h73, 7'h63, 7'h6B, 7'h74,
         7'h5A, 7'h53, 7'h43, 7'h4B, 7'h54: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Code of the digraph formed by a lead letter followed by a small h.
   function automatic logic [15:0] digraph_code(input logic [6:0] c);
      case (c)
         7'h7A: return 16'h0436;
         7'h73: return 16'h0448;
         7'h63: return 16'h0447;
         7'h6B: return 16'h0445;
         7'h74: return 16'h0437;
         7'h5A: return 16'h0416;
         7'h53: return 16'h0428;
         7'h43: return 16'h0427;
         7'h4B: return 16'h0425;
         7'h54: return 16'h0417;
         default: return 16'h0000;
      endcase
   endfunction

endpackage

`default_nettype wire

/* design/l2c_req_if.sv */
`default_nettype none

interface l2c_req_if #(
   parameter int CHAR_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 text_end;

   modport source (output valid, output char_code, output text_end, input ready);
   modport sink   (input valid, input char_code, input text_end, output ready);
endinterface

`default_nettype wire

/* design/l2c_rsp_if.sv */
`default_nettype none

interface l2c_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_code;
   logic        run_last;
   logic        text_done;

   modport source (output valid, output out_code, output run_last, output text_done,
                   input ready);
   modport sink   (input valid, input out_code, input run_last, input text_done,
                   output ready);
endinterface

`default_nettype wire

/* design/latin_to_cyrillic_transliterator_top.sv */
`default_nettype none

// Latin to Cyrillic transliterator. Each request transaction carries one Latin
// code unit; the block matches greedily, longest spelling first, and returns
// from zero to four Cyrillic code units as response transactions, the last one
// of each request flagged by run_last, and the final one of the text also by
// text_done. Up to three letters of a possible digraph or of shch are held
// back until they are decided or text_end flushes them. A request is decided
// in the cycle it is accepted and its results are loaded into a four-entry
// result buffer that drains one transaction per cycle while the receiver is
// ready; a plain letter gives one result, x gives two, and a broken held shc
// gives up to four. The next request is taken in the same cycle as the last
// result of the previous one.
module latin_to_cyrillic_transliterator_top #(
   parameter int CHAR_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   l2c_req_if.sink    req_ch,
   l2c_rsp_if.source  rsp_ch
);

   // Lookahead state: number of held letters and the first of them.
   // The second held letter is always h and the third always c.
   logic [1:0]  count_ff, count_in;
   logic [6:0]  p0_ff, p0_in;

   // Result buffer.
   logic [15:0] res_ff [4];
   logic [15:0] res_in [4];
   logic [2:0]  left_ff, left_in;
   logic [1:0]  ptr_ff, ptr_in;
   logic        end_ff, end_in;

   logic        accept;
   logic        take;

   logic [CHAR_BITS-1:0] x;
   logic [6:0]  x7;
   logic        x_ascii;
   logic        x_is_h;
   logic        x_is_c;
   logic        text_end;

   // Decision of the incoming character on its own.
   logic        tail_wait;
   logic [15:0] tail_code [2];
   logic [1:0]  tail_n;

   logic [15:0] pre [2];
   logic [1:0]  pre_n;
   logic [15:0] tl [2];
   logic [1:0]  tl_n;
   logic [2:0]  res_n;
   logic [2:0]  k;

   assign take   = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;

   assign x        = req_ch.char_code;
   assign x7       = x[6:0];
   assign x_ascii  = (x[CHAR_BITS-1:7] == '0);
   assign x_is_h   = x_ascii && (x7 == l2c_pkg::CH_LC_H);
   assign x_is_c   = x_ascii && (x7 == l2c_pkg::CH_LC_C);
   assign text_end = req_ch.text_end;

   // The incoming character treated as the start of a fresh match.
   always_comb begin
      tail_wait    = !text_end && x_ascii && l2c_pkg::is_lead(x7);
      tail_code[1] = l2c_pkg::CYR_LC_ES;
      if (x_ascii && l2c_pkg::is_letter(x7)) begin
         tail_code[0] = l2c_pkg::letter_code(x7);
      end else begin
         tail_code[0] = x[15:0];
      end
      if (tail_wait) begin
         tail_n = 2'd0;
      end else if (x_ascii && ((x7 == l2c_pkg::CH_LC_X) || (x7 == l2c_pkg::CH_UC_X))) begin
         tail_n = 2'd2;
      end else begin
         tail_n = 2'd1;
      end
   end

   // Greedy match of the held letters followed by the incoming character.
   always_comb begin
      pre[0]   = l2c_pkg::digraph_code(p0_ff);
      pre[1]   = l2c_pkg::CYR_LC_KA;
      pre_n    = 2'd0;
      tl       = tail_code;
      tl_n     = tail_n;
      count_in = tail_wait ? 2'd1 : 2'd0;
      p0_in    = tail_wait ? x7 : p0_ff;
      case (count_ff)
         2'd0: begin
         end
         2'd1: begin
            if (x_is_h) begin
               p0_in = p0_ff;
               if (!text_end && ((p0_ff == l2c_pkg::CH_UC_S) ||
                                 (p0_ff == l2c_pkg::CH_LC_S))) begin
                  tl_n     = 2'd0;
                  count_in = 2'd2;
               end else begin
                  tl[0]    = l2c_pkg::digraph_code(p0_ff);
                  tl_n     = 2'd1;
                  count_in = 2'd0;
               end
            end else begin
               pre[0] = l2c_pkg::letter_code(p0_ff);
               pre_n  = 2'd1;
            end
         end
         2'd2: begin
            if (x_is_c && !text_end) begin
               p0_in    = p0_ff;
               tl_n     = 2'd0;
               count_in = 2'd3;
            end else begin
               pre_n = 2'd1;
            end
         end
         default: begin
            if (x_is_h) begin
               p0_in    = p0_ff;
               tl[0]    = (p0_ff == l2c_pkg::CH_UC_S) ? l2c_pkg::CYR_UC_SHCHA
                                                       : l2c_pkg::CYR_LC_SHCHA;
               tl_n     = 2'd1;
               count_in = 2'd0;
            end else begin
               pre_n = 2'd2;
            end
         end
      endcase
      if (text_end) begin
         count_in = 2'd0;
      end
   end

   // Results in order: the flushed prefix, then the tail.
   always_comb begin
      res_n = {1'b0, pre_n} + {1'b0, tl_n};
      for (int i = 0; i < 4; i++) begin
         k = 3'(i) - {1'b0, pre_n};
         if (3'(i) < {1'b0, pre_n}) begin
            res_in[i] = pre[1'(i)];
         end else begin
            res_in[i] = tl[k[0]];
         end
      end
   end

   // Buffer control: load on a new request, otherwise step on each transaction.
   always_comb begin
      left_in = left_ff;
      ptr_in  = ptr_ff;
      end_in  = end_ff;
      if (accept) begin
         left_in = res_n;
         ptr_in  = 2'd0;
         end_in  = text_end;
      end else if (take) begin
         left_in = left_ff - 3'd1;
         ptr_in  = ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         left_ff  <= 3'd0;
      end else begin
         left_ff <= left_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      end_ff <= end_in;
      if (accept) begin
         p0_ff  <= p0_in;
         res_ff <= res_in;
      end
   end

   // Response channel.
   assign rsp_ch.valid     = (left_ff != 3'd0);
   assign rsp_ch.out_code  = res_ff[ptr_ff];
   assign rsp_ch.run_last  = (left_ff == 3'd1);
   assign rsp_ch.text_done = (left_ff == 3'd1) && end_ff;

endmodule

`default_nettype wire

/* tb/l2c_tb_pkg.sv */
package l2c_tb_pkg;

   // One Cyrillic code unit as the response channel carries it.
   typedef struct packed {
      logic [15:0] out_code;
      logic        run_last;
      logic        text_done;
   } cyr_unit_type;

   localparam int SPELLING_COUNT = 12;
   localparam int MAX_UNITS      = 4;

   // Letter table for the capitals A to Z and the small letters a to z.
   localparam logic [15:0] UPPER_CYR [26] = '{
      16'h0410, 16'h0411, 16'h041A, 16'h0414, 16'h0415, 16'h0424, 16'h0490,
      16'h0413, 16'h0406, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D,
      16'h041E, 16'h041F, 16'h041A, 16'h0420, 16'h0421, 16'h0422, 16'h0423,
      16'h0412, 16'h0412, 16'h041A, 16'h0418, 16'h0417
   };
   localparam logic [15:0] LOWER_CYR [26] = '{
      16'h0430, 16'h0431, 16'h043A, 16'h0434, 16'h0435, 16'h0444, 16'h0491,
      16'h0433, 16'h0456, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D,
      16'h043E, 16'h043F, 16'h043A, 16'h0440, 16'h0441, 16'h0442, 16'h0443,
      16'h0432, 16'h0432, 16'h043A, 16'h0438, 16'h0437
   };

   // Multi-letter spellings and the single Cyrillic letter each one becomes.
   function automatic void spelling_of(input int idx, output string txt,
                                       output logic [15:0] code);
      case (idx)
         0:  begin txt = "shch"; code = 16'h0449; end
         1:  begin txt = "Shch"; code = 16'h0429; end
         2:  begin txt = "zh";   code = 16'h0436; end
         3:  begin txt = "sh";   code = 16'h0448; end
         4:  begin txt = "ch";   code = 16'h0447; end
         5:  begin txt = "kh";   code = 16'h0445; end
         6:  begin txt = "Zh";   code = 16'h0416; end
         7:  begin txt = "Sh";   code = 16'h0428; end
         8:  begin txt = "Ch";   code = 16'h0427; end
         9:  begin txt = "Kh";   code = 16'h0425; end
         10: begin txt = "Th";   code = 16'h0417; end
         default: begin txt = "th"; code = 16'h0437; end
      endcase
   endfunction

   // Predicts the Cyrillic stream and holds the units still to arrive.
   class cyrillic_scoreboard;
      cyr_unit_type cyrillic_due[$];
      cyr_unit_type fresh[$];
      logic [15:0]  held[3];
      logic [15:0]  window[4];
      int unsigned  held_count;
      int unsigned  errors;

      function new();
         held_count = 0;
         errors     = 0;
      endfunction

      function void add_unit(input logic [15:0] code);
         if (fresh.size() < MAX_UNITS) fresh.push_back({code, 1'b0, 1'b0});
      endfunction

      // True when the n characters from pos may still grow into a longer spelling.
      function bit prefix_of_longer(input int unsigned pos, input int unsigned n);
         string       txt;
         logic [15:0] code;
         bit          ok;
         for (int idx = 0; idx < SPELLING_COUNT; idx++) begin
            spelling_of(idx, txt, code);
            if (txt.len() <= n) continue;
            ok = 1'b1;
            for (int k = 0; k < n; k++)
               if (window[pos + k] != {8'h00, txt[k]}) ok = 1'b0;
            if (ok) return 1'b1;
         end
         return 1'b0;
      endfunction

      // Longest spelling that starts at pos; a length of zero means none.
      function void longest_spelling(input int unsigned pos, input int unsigned n,
                                     output logic [15:0] best_code,
                                     output int unsigned best_len);
         string       txt;
         logic [15:0] code;
         bit          ok;
         best_len  = 0;
         best_code = '0;
         for (int idx = 0; idx < SPELLING_COUNT; idx++) begin
            spelling_of(idx, txt, code);
            if (txt.len() > n || txt.len() <= best_len) continue;
            ok = 1'b1;
            for (int k = 0; k < txt.len(); k++)
               if (window[pos + k] != {8'h00, txt[k]}) ok = 1'b0;
            if (ok) begin
               best_code = code;
               best_len  = txt.len();
            end
         end
      endfunction

      // A single character: x and X give two letters, other letters use the table.
      function void add_single(input logic [15:0] c);
         if (c == {9'h000, l2c_pkg::CH_LC_X}) begin
            add_unit(l2c_pkg::CYR_LC_KA);
            add_unit(l2c_pkg::CYR_LC_ES);
         end else if (c == {9'h000, l2c_pkg::CH_UC_X}) begin
            add_unit(16'h041A);
            add_unit(l2c_pkg::CYR_LC_ES);
         end else if (c >= {9'h000, l2c_pkg::CH_UC_A} && c <= {9'h000, l2c_pkg::CH_UC_Z}) begin
            add_unit(UPPER_CYR[c - {9'h000, l2c_pkg::CH_UC_A}]);
         end else if (c >= {9'h000, l2c_pkg::CH_LC_A} && c <= {9'h000, l2c_pkg::CH_LC_Z}) begin
            add_unit(LOWER_CYR[c - {9'h000, l2c_pkg::CH_LC_A}]);
         end else begin
            add_unit(c);
         end
      endfunction

      // Notes an accepted Latin character and queues the units that it decides.
      function void take_latin(input logic [15:0] code, input logic text_end);
         int unsigned n;
         int unsigned pos;
         int unsigned mlen;
         logic [15:0] mcode;
         fresh.delete();
         for (int k = 0; k < held_count; k++) window[k] = held[k];
         window[held_count] = code;
         n   = held_count + 1;
         pos = 0;
         while (pos < n) begin
            if (!text_end && prefix_of_longer(pos, n - pos)) break;
            longest_spelling(pos, n - pos, mcode, mlen);
            if (mlen > 0) begin
               add_unit(mcode);
               pos += mlen;
            end else begin
               add_single(window[pos]);
               pos += 1;
            end
         end
         // The end of the text empties the lookahead; otherwise the rest is held.
         if (text_end) begin
            held_count = 0;
         end else begin
            held_count = (n - pos > 3) ? 3 : n - pos;
            for (int k = 0; k < held_count; k++) held[k] = window[pos + k];
         end
         if (fresh.size() > 0) begin
            fresh[fresh.size() - 1].run_last  = 1'b1;
            fresh[fresh.size() - 1].text_done = text_end;
         end
         foreach (fresh[i]) cyrillic_due.push_back(fresh[i]);
      endfunction

      // Compares an accepted response transaction with the oldest expected unit.
      function void check_cyrillic(input logic [15:0] code, input logic run_last,
                                   input logic text_done);
         cyr_unit_type due;
         if (cyrillic_due.size() == 0) begin
            errors++;
            $display("%0t: response expected none, actual out_code=%h run_last=%b text_done=%b",
                     $time, code, run_last, text_done);
            return;
         end
         due = cyrillic_due.pop_front();
         if (due.out_code !== code) begin
            errors++;
            $display("%0t: out_code expected %h, actual %h", $time, due.out_code, code);
         end
         if (due.run_last !== run_last) begin
            errors++;
            $display("%0t: run_last expected %b, actual %b", $time, due.run_last,
                     run_last);
         end
         if (due.text_done !== text_done) begin
            errors++;
            $display("%0t: text_done expected %b, actual %b", $time, due.text_done,
                     text_done);
         end
      endfunction

      function int outstanding();
         return cyrillic_due.size();
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
module tb_top;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 60;

   logic clock;
   logic reset;

   l2c_req_if #(.CHAR_BITS(16)) req_ch ();
   l2c_rsp_if                   rsp_ch ();

   latin_to_cyrillic_transliterator_top #(.CHAR_BITS(16)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   l2c_tb_pkg::cyrillic_scoreboard sb;
   int unsigned        sent_items   = 0;
   int unsigned        idle_cycles  = 0;
   bit                 calm         = 1'b0;
   bit                 sender_idles = 1'b1;
   bit                 hold_req     = 1'b0;

   // Free-running clock with a period of 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: random stalls and steady stretches, a long hold-off on request.
   initial begin
      int hold_left;
      int stall_left;
      int steady_left;
      hold_left   = 0;
      stall_left  = 0;
      steady_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (steady_left > 0) begin
            steady_left--;
            rsp_ch.ready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            steady_left = $urandom_range(0, 30);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: notes request transactions, checks responses and guards against a hang.
   always @(posedge clock) begin
      bit progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.take_latin(req_ch.char_code, req_ch.text_end);
            progress = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_cyrillic(rsp_ch.out_code, rsp_ch.run_last, rsp_ch.text_done);
            progress = 1'b1;
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("tb_top: FAIL");
               $finish;
            end
         end
      end
   end

   // Offers one character, at times after a random gap, and returns once it is accepted.
   task automatic send_item(input logic [15:0] code, input logic text_end);
      int gap;
      if (sender_idles && !calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      req_ch.text_end  <= text_end;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
   endtask

   task automatic send_text(input string txt, input bit end_last);
      for (int k = 0; k < txt.len(); k++)
         send_item({8'h00, txt[k]}, end_last && (k == txt.len() - 1));
   endtask

   // Stops offering and waits until every expected unit has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Random character, weighted towards letters that open or close a spelling.
   function automatic logic [15:0] random_char();
      string mix;
      int    r;
      byte   ch;
      mix = "shcShCzZkKtTxXhhH";
      r   = $urandom_range(0, 99);
      if (r < 40) return {8'h00, mix[$urandom_range(0, mix.len() - 1)]};
      if (r < 70) begin
         if ($urandom_range(0, 1) == 1)
            return 16'($urandom_range(0, 25)) + {9'h000, l2c_pkg::CH_UC_A};
         return 16'($urandom_range(0, 25)) + {9'h000, l2c_pkg::CH_LC_A};
      end
      if (r < 82) return 16'($urandom_range(0, 127));
      if (r < 94) return 16'($urandom());
      // A letter code with upper bits set must not be taken for the letter.
      ch = mix[$urandom_range(0, mix.len() - 1)];
      return {8'($urandom_range(1, 255)), ch};
   endfunction

   // A chunk of text: mostly whole spellings, some broken ones and some noise.
   task automatic send_chunk();
      string       txt;
      logic [15:0] code;
      int          kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         l2c_tb_pkg::spelling_of($urandom_range(0, l2c_tb_pkg::SPELLING_COUNT - 1), txt,
                                 code);
      end else if (kind == 6) begin
         txt = ($urandom_range(0, 1) == 1) ? "shch" : "Shch";
         txt = txt.substr(0, $urandom_range(0, 2));
      end else begin
         txt = "";
         repeat ($urandom_range(1, 3)) send_item(random_char(), $urandom_range(0, 11) == 0);
      end
      for (int k = 0; k < txt.len(); k++)
         send_item({8'h00, txt[k]}, $urandom_range(0, 11) == 0);
   endtask

   // Stimulus sequence.
   initial begin
      sb = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      req_ch.text_end  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: the four-letter spelling, a broken one, digraphs, x and X,
      // a flush at the end of the text and the extreme codes.
      send_text("shch", 1'b0);
      send_text("Shcx", 1'b0);
      send_text("zhKh", 1'b0);
      send_text("thTh", 1'b0);
      send_text("xX", 1'b1);
      send_text("Shc", 1'b1);
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b1);
      send_item(16'h0173, 1'b0);
      send_item(16'h0068, 1'b1);
      wait_drained();

      // Random text with idling on both sides.
      while (sent_items < 160) send_chunk();

      // The receiver holds off while the sender keeps offering without gaps.
      hold_req     = 1'b1;
      sender_idles = 1'b0;
      while (sent_items < 200) send_chunk();
      sender_idles = 1'b1;

      while (sent_items < 300) send_chunk();
      wait_drained();
      while (sent_items < 400) send_chunk();

      // Last part of the run without idling.
      calm = 1'b1;
      while (sent_items < 470) send_chunk();
      send_item(16'h002E, 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
